@@ rtl/wtdb_pkg.sv @@
// ----------------------------------------------------------------------------
// wtdb_pkg
// Types and constants shared by the transmit descriptor builder.
// ----------------------------------------------------------------------------
`default_nettype none

package wtdb_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_MALFORMED   = 2'd1,
    ST_INVALID     = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_EP_COUNT  = 3'd0,
    REG_EP_HIGH   = 3'd1,
    REG_EP_NORMAL = 3'd2,
    REG_EP_LOW    = 3'd3,
    REG_MIN_HDR   = 3'd4,
    REG_MAX_KEY   = 3'd5
  } reg_idx_e;

  localparam int unsigned DescWords = 8;

  localparam logic [4:0]  QueueBestEffort = 5'h00;
  localparam logic [4:0]  QueueMgmt       = 5'h12;
  localparam logic [31:0] DescIdEnable    = 32'h0020_0000;
  localparam logic [31:0] SecTkip         = 32'h0040_0000;
  localparam logic [31:0] SecAes          = 32'h00c0_0000;
  localparam logic [31:0] AggBreak        = 32'h0001_0000;
  localparam logic [31:0] AntA            = 32'h0100_0000;
  localparam logic [31:0] AntB            = 32'h0200_0000;
  localparam logic [31:0] AntC            = 32'h2000_0000;
  localparam logic [31:0] DriverRate      = 32'h0000_0100;
  localparam logic [31:0] DataFallback    = 32'h0001_ff00;
  localparam logic [31:0] RetryEnable     = 32'h0002_0000;
  localparam logic [31:0] MgmtRetries     = 32'h0018_0000; // 6 << 18
  localparam logic [7:0]  RateTableBg     = 8'd4;
  localparam logic [7:0]  RateTableB      = 8'd6;
  localparam logic [7:0]  DescBytes       = 8'd32;
  localparam logic [7:0]  Word0Flags      = 8'h8c;

  typedef struct packed {
    status_e                     status;
    logic [4:0]                  queue;
    logic [7:0]                  endpoint;
    logic [DescWords-1:0][31:0]  words;
  } desc_t;

endpackage

`default_nettype wire

@@ rtl/wifi_tx_descriptor_builder.sv @@
// ----------------------------------------------------------------------------
// wifi_tx_descriptor_builder
// Checks a frame request and emits its 32-byte transmit descriptor.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid_i/in_ready_o  | frame fields, one word per frame
//  result   | out_valid_o/out_ready_i| status, index, dword, queue, ep, last
//  config   | cfg_we_i               | cfg_index_i, cfg_data_i, no wait
//
//  A frame gives eight result words (one on a failed check), one per cycle
//  while out_ready_i holds; the result channel sets the sustained frame rate.
//  Input register feeds the descriptor buffer; a second frame is held
//  in the input register while the buffer drains, so no bubble between frames.
//  Reset clears valids and loads the register defaults; no clearing pass.
//  Output stalls hold the current word and back up into in_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module wifi_tx_descriptor_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        frame_length_i,
  input  logic [15:0]        frame_ctrl_i,
  input  logic               receiver_group_i,
  input  logic [11:0]        seq_num_i,
  input  logic signed [5:0]  key_slot_i,
  input  logic [1:0]         cipher_kind_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [2:0]         word_index_o,
  output logic [31:0]        descriptor_word_o,
  output logic [4:0]         queue_id_o,
  output logic [7:0]         endpoint_o,
  output logic               last_o
);
  import wtdb_pkg::*;

  logic [3:0] ep_count_q;
  logic [7:0] ep_high_q, ep_normal_q, ep_low_q, min_hdr_q;
  logic [4:0] max_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_count_q  <= 4'd1;
      ep_high_q   <= 8'd0;
      ep_normal_q <= 8'd0;
      ep_low_q    <= 8'd0;
      min_hdr_q   <= 8'd24;
      max_key_q   <= 5'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_EP_COUNT:  ep_count_q  <= cfg_data_i[3:0];
        REG_EP_HIGH:   ep_high_q   <= cfg_data_i;
        REG_EP_NORMAL: ep_normal_q <= cfg_data_i;
        REG_EP_LOW:    ep_low_q    <= cfg_data_i;
        REG_MIN_HDR:   min_hdr_q   <= cfg_data_i;
        REG_MAX_KEY:   max_key_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              s1_valid_q, s1_valid_d;
  logic [15:0]       len_q, fc_q;
  logic              grp_q;
  logic [11:0]       seq_q;
  logic signed [5:0] key_q;
  logic [1:0]        cipher_q;

  logic  busy, done, advance;
  desc_t desc;

  assign advance    = s1_valid_q && (!busy || done);
  assign in_ready_o = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      len_q    <= frame_length_i;
      fc_q     <= frame_ctrl_i;
      grp_q    <= receiver_group_i;
      seq_q    <= seq_num_i;
      key_q    <= key_slot_i;
      cipher_q <= cipher_kind_i;
    end
  end

  wtdb_build u_build (
    .frame_length_i     (len_q),
    .frame_ctrl_i       (fc_q),
    .receiver_group_i   (grp_q),
    .seq_num_i          (seq_q),
    .key_slot_i         (key_q),
    .cipher_kind_i      (cipher_q),
    .endpoint_count_i   (ep_count_q),
    .endpoint_high_i    (ep_high_q),
    .endpoint_normal_i  (ep_normal_q),
    .endpoint_low_i     (ep_low_q),
    .min_header_bytes_i (min_hdr_q),
    .max_key_slot_i     (max_key_q),
    .desc_o             (desc)
  );

  wtdb_serial u_serial (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (advance),
    .desc_i            (desc),
    .busy_o            (busy),
    .done_o            (done),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .word_index_o      (word_index_o),
    .descriptor_word_o (descriptor_word_o),
    .queue_id_o        (queue_id_o),
    .endpoint_o        (endpoint_o),
    .last_o            (last_o)
  );

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty register");

  a_held_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(len_q) && $stable(seq_q))
    else $error("held word lost");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o && word_index_o == 3'd0)
    else $error("loaded descriptor not presented");

endmodule

`default_nettype wire

@@ rtl/wtdb_build.sv @@
// ----------------------------------------------------------------------------
// wtdb_build
// Frame checks, queue and endpoint choice and descriptor assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module wtdb_build (
  input  logic [15:0]        frame_length_i,
  input  logic [15:0]        frame_ctrl_i,
  input  logic               receiver_group_i,
  input  logic [11:0]        seq_num_i,
  input  logic signed [5:0]  key_slot_i,
  input  logic [1:0]         cipher_kind_i,
  input  logic [3:0]         endpoint_count_i,
  input  logic [7:0]         endpoint_high_i,
  input  logic [7:0]         endpoint_normal_i,
  input  logic [7:0]         endpoint_low_i,
  input  logic [7:0]         min_header_bytes_i,
  input  logic [4:0]         max_key_slot_i,
  output wtdb_pkg::desc_t    desc_o
);
  import wtdb_pkg::*;

  logic [1:0]  ftype;
  logic        sub_qos;
  logic        key_absent;
  logic        key_bad;
  logic        is_mgmt;
  logic        is_data;
  status_e     status;
  logic [4:0]  queue;
  logic [7:0]  endpoint;
  logic [31:0] sec_bits;
  logic [15:0] csum;
  logic [DescWords-1:0][31:0] w;

  assign ftype      = frame_ctrl_i[3:2];
  assign sub_qos    = frame_ctrl_i[7];
  assign key_absent = key_slot_i[5];
  // below -1, or above the largest slot
  assign key_bad    = key_absent ? (key_slot_i != -6'sd1)
                                 : (key_slot_i[4:0] > max_key_slot_i);
  assign is_mgmt    = (ftype == 2'd0);
  assign is_data    = (ftype == 2'd2) && !sub_qos;

  always_comb begin
    if ({8'd0, min_header_bytes_i} > frame_length_i) begin
      status = ST_MALFORMED;
    end else if (key_bad || (key_absent != (cipher_kind_i == 2'd0))) begin
      status = ST_INVALID;
    end else if (!is_mgmt && !is_data) begin
      status = ST_UNSUPPORTED;
    end else if (!key_absent && !is_data) begin
      status = ST_INVALID;
    end else if (!key_absent && (cipher_kind_i == 2'd3)) begin
      status = ST_UNSUPPORTED;
    end else begin
      status = ST_OK;
    end
  end

  assign queue = is_mgmt ? QueueMgmt : QueueBestEffort;

  always_comb begin
    if (is_mgmt || endpoint_count_i < 4'd2) begin
      endpoint = endpoint_high_i;
    end else if (endpoint_count_i == 4'd2) begin
      endpoint = endpoint_normal_i;
    end else begin
      endpoint = endpoint_low_i;
    end
  end

  always_comb begin
    sec_bits = '0;
    if (!key_absent) begin
      sec_bits = (cipher_kind_i == 2'd2) ? SecAes : SecTkip;
      if (receiver_group_i) begin
        sec_bits = sec_bits | DescIdEnable | {27'd0, key_slot_i[4:0]};
      end
    end
  end

  always_comb begin
    w[0] = {Word0Flags | {7'd0, receiver_group_i}, DescBytes, frame_length_i};
    w[1] = {8'd0, ((ftype == 2'd2) && !receiver_group_i) ? RateTableBg : RateTableB,
            3'd0, queue, 8'd0} | sec_bits;
    w[2] = AggBreak | AntA | AntB;
    w[3] = {4'd0, seq_num_i, 16'd0};
    w[4] = DriverRate;
    w[5] = is_mgmt ? (RetryEnable | MgmtRetries) : DataFallback;
    w[6] = '0;
    w[7] = AntC;
  end

  // XOR of all halfwords; word 7 low half is zero before the fold
  always_comb begin
    csum = '0;
    for (int i = 0; i < DescWords; i++) begin
      csum = csum ^ w[i][15:0] ^ w[i][31:16];
    end
  end

  always_comb begin
    desc_o.status   = status;
    desc_o.queue    = '0;
    desc_o.endpoint = '0;
    desc_o.words    = '0;
    if (status == ST_OK) begin
      desc_o.queue    = queue;
      desc_o.endpoint = endpoint;
      desc_o.words    = w;
      desc_o.words[7] = {w[7][31:16], csum};
    end
  end

endmodule

`default_nettype wire

@@ rtl/wtdb_serial.sv @@
// ----------------------------------------------------------------------------
// wtdb_serial
// Descriptor buffer; shifts the words out one per accepted result.
// ----------------------------------------------------------------------------
`default_nettype none

module wtdb_serial (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  wtdb_pkg::desc_t  desc_i,
  output logic             busy_o,
  output logic             done_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [2:0]       word_index_o,
  output logic [31:0]      descriptor_word_o,
  output logic [4:0]       queue_id_o,
  output logic [7:0]       endpoint_o,
  output logic             last_o
);
  import wtdb_pkg::*;

  logic       valid_q, valid_d;
  logic [2:0] idx_q, idx_d;
  desc_t      desc_q, desc_d;
  logic       err;
  logic       take;

  assign err  = (desc_q.status != ST_OK);
  assign take = valid_q && out_ready_i;

  assign last_o            = err || (idx_q == 3'd7);
  assign out_valid_o       = valid_q;
  assign status_o          = desc_q.status;
  assign word_index_o      = idx_q;
  assign descriptor_word_o = desc_q.words[0];
  assign queue_id_o        = desc_q.queue;
  assign endpoint_o        = desc_q.endpoint;
  assign busy_o            = valid_q;
  assign done_o            = take && last_o;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    desc_d  = desc_q;
    if (take) begin
      idx_d        = idx_q + 3'd1;
      desc_d.words = {32'd0, desc_q.words[DescWords-1:1]};
      if (last_o) begin
        valid_d = 1'b0;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
      desc_d  = desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && err |-> last_o && idx_q == 3'd0 && descriptor_word_o == 32'd0)
    else $error("error word malformed");

  a_word_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !last_o |=> valid_q && idx_q == $past(idx_q) + 3'd1
                        && status_o == $past(status_o))
    else $error("descriptor word sequence broken");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !valid_q || done_o)
    else $error("buffer loaded while busy");

endmodule

`default_nettype wire

@@ tb/wtdb_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wtdb_tb_pkg
// Frame field codes and the request type used by the descriptor builder bench.
// ----------------------------------------------------------------------------

package wtdb_tb_pkg;

  localparam logic [1:0] CipherNone  = 2'd0;
  localparam logic [1:0] CipherTkip  = 2'd1;
  localparam logic [1:0] CipherCcmp  = 2'd2;
  localparam logic [1:0] CipherOther = 2'd3;

  // frame control type field, bits 3:2
  localparam logic [1:0] FtypeMgmt = 2'd0;
  localparam logic [1:0] FtypeCtrl = 2'd1;
  localparam logic [1:0] FtypeData = 2'd2;
  localparam logic [1:0] FtypeExt  = 2'd3;

  // key slot -1 as a raw 6-bit field: frame goes out in clear
  localparam logic [5:0] KeyNone = 6'h3f;

  // indexes past the register list, ignored by the block
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [15:0] len;
    logic [15:0] fc;
    logic        grp;
    logic [11:0] seq;
    logic [5:0]  key;
    logic [1:0]  cipher;
  } frame_t;

endpackage

@@ tb/wtdb_descriptor_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wtdb_descriptor_monitor
// Watches the register port and both channels of the descriptor builder,
// works out the descriptor words each accepted frame must give and compares
// every accepted result word against the oldest one still owed.
// ----------------------------------------------------------------------------

module wtdb_descriptor_monitor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [15:0]       frame_length_i,
  input  logic [15:0]       frame_ctrl_i,
  input  logic              receiver_group_i,
  input  logic [11:0]       seq_num_i,
  input  logic signed [5:0] key_slot_i,
  input  logic [1:0]        cipher_kind_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [1:0]        status_i,
  input  logic [2:0]        word_index_i,
  input  logic [31:0]       descriptor_word_i,
  input  logic [4:0]        queue_id_i,
  input  logic [7:0]        endpoint_i,
  input  logic              last_i,
  output int unsigned       fail_count_o,
  output int unsigned       frames_done_o
);
  import wtdb_pkg::*;
  import wtdb_tb_pkg::*;

  localparam logic [4:0]  QidBestEffort    = 5'd0;
  localparam logic [4:0]  QidMgmt          = 5'd18;
  localparam logic [7:0]  Word0Flags       = 8'h8c;
  localparam logic [7:0]  DescLenBytes     = 8'd32;
  localparam logic [7:0]  RateTblBg        = 8'd4;
  localparam logic [7:0]  RateTblB         = 8'd6;
  localparam logic [31:0] SecTkipBits      = 32'h0040_0000;
  localparam logic [31:0] SecAesBits       = 32'h00c0_0000;
  localparam logic [31:0] KeyIdEnable      = 32'h0020_0000;
  localparam logic [31:0] Word2Fixed       = 32'h0301_0000; // agg break, ant A and B
  localparam logic [31:0] Word4Fixed       = 32'h0000_0100; // driver rate
  localparam logic [31:0] MgmtRetryWord    = 32'h001a_0000; // retry en, 6 retries
  localparam logic [31:0] DataFallbackWord = 32'h0001_ff00;
  localparam logic [31:0] Word7Fixed       = 32'h2000_0000; // ant C
  localparam int unsigned ReportLimit      = 10;

  typedef struct packed {
    status_e     status;
    logic [2:0]  idx;
    logic [31:0] word;
    logic [4:0]  qid;
    logic [7:0]  ep;
    logic        last;
  } desc_word_t;

  desc_word_t  expected_words[$];
  int unsigned mismatches;

  logic [3:0] ep_count;
  logic [7:0] ep_high, ep_normal, ep_low, min_hdr;
  logic [4:0] max_key;

  function automatic void predict_frame(input logic [15:0] len, input logic [15:0] fc,
                                        input logic grp, input logic [11:0] seq,
                                        input logic signed [5:0] key,
                                        input logic [1:0] cipher);
    logic [1:0]        ftype;
    int                slot;
    status_e           err;
    logic [4:0]        qid;
    logic [7:0]        ep;
    logic [7:0]        rate;
    logic [7:0][31:0]  w;
    logic [15:0]       csum;
    desc_word_t        e;
    ftype = fc[3:2];
    slot  = key;
    err   = ST_OK;
    if (len < {8'd0, min_hdr})
      err = ST_MALFORMED;
    else if (slot < -1 || slot > int'(max_key))
      err = ST_INVALID;
    else if ((slot < 0) != (cipher == CipherNone))
      err = ST_INVALID;
    else if (!(ftype == FtypeMgmt || (ftype == FtypeData && !fc[7])))
      err = ST_UNSUPPORTED;
    else if (slot >= 0 && ftype != FtypeData)
      err = ST_INVALID;
    else if (slot >= 0 && cipher == CipherOther)
      err = ST_UNSUPPORTED;

    if (err != ST_OK) begin
      e = '0;
      e.status = err;
      e.last = 1'b1;
      expected_words.push_back(e);
      return;
    end

    qid  = (ftype == FtypeMgmt) ? QidMgmt : QidBestEffort;
    rate = (ftype == FtypeData && !grp) ? RateTblBg : RateTblB;
    w[0] = {Word0Flags | {7'd0, grp}, DescLenBytes, len};
    w[1] = {8'd0, rate, 3'd0, qid, 8'd0};
    if (slot >= 0) begin
      w[1] |= (cipher == CipherCcmp) ? SecAesBits : SecTkipBits;
      if (grp) begin
        w[1] |= KeyIdEnable | {27'd0, key[4:0]};
      end
    end
    w[2] = Word2Fixed;
    w[3] = {4'd0, seq, 16'd0};
    w[4] = Word4Fixed;
    w[5] = (ftype == FtypeMgmt) ? MgmtRetryWord : DataFallbackWord;
    w[6] = '0;
    w[7] = Word7Fixed;
    csum = '0;
    for (int i = 0; i < 8; i++) csum ^= w[i][15:0] ^ w[i][31:16];
    w[7][15:0] = csum;

    if (qid == QidMgmt)      ep = ep_high;
    else if (ep_count >= 3)  ep = ep_low;
    else if (ep_count == 2)  ep = ep_normal;
    else                     ep = ep_high;

    for (int i = 0; i < 8; i++) begin
      e.status = ST_OK;
      e.idx    = 3'(i);
      e.word   = w[i];
      e.qid    = qid;
      e.ep     = ep;
      e.last   = (i == 7);
      expected_words.push_back(e);
    end
  endfunction

  function automatic void check_word();
    desc_word_t got, want;
    got.status = status_e'(status_i);
    got.idx    = word_index_i;
    got.word   = descriptor_word_i;
    got.qid    = queue_id_i;
    got.ep     = endpoint_i;
    got.last   = last_i;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("%0t: word with nothing owed: st=%0d idx=%0d dw=%08h q=%0d ep=%0d last=%0b",
                 $time, got.status, got.idx, got.word, got.qid, got.ep, got.last);
      return;
    end
    want = expected_words.pop_front();
    if (got.status !== want.status || got.idx !== want.idx || got.word !== want.word ||
        got.qid !== want.qid || got.ep !== want.ep || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("%0t: word mismatch, want st=%0d idx=%0d dw=%08h q=%0d ep=%0d last=%0b",
                 $time, want.status, want.idx, want.word, want.qid, want.ep, want.last);
        $display("%0t:                got  st=%0d idx=%0d dw=%08h q=%0d ep=%0d last=%0b",
                 $time, got.status, got.idx, got.word, got.qid, got.ep, got.last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_count  = 4'd1;
      ep_high   = 8'd0;
      ep_normal = 8'd0;
      ep_low    = 8'd0;
      min_hdr   = 8'd24;
      max_key   = 5'd3;
      mismatches = 0;
      expected_words.delete();
      fail_count_o  <= 0;
      frames_done_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_word();
        if (last_i) frames_done_o <= frames_done_o + 1;
      end
      if (in_valid_i && in_ready_i)
        predict_frame(frame_length_i, frame_ctrl_i, receiver_group_i,
                      seq_num_i, key_slot_i, cipher_kind_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_EP_COUNT:  ep_count  = cfg_data_i[3:0];
          REG_EP_HIGH:   ep_high   = cfg_data_i;
          REG_EP_NORMAL: ep_normal = cfg_data_i;
          REG_EP_LOW:    ep_low    = cfg_data_i;
          REG_MIN_HDR:   min_hdr   = cfg_data_i;
          REG_MAX_KEY:   max_key   = cfg_data_i[4:0];
          default: ;
        endcase
      end
      // words still owed count against the run as well
      fail_count_o <= mismatches + expected_words.size();
    end
  end

endmodule

@@ tb/wifi_tx_descriptor_builder_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wifi_tx_descriptor_builder_test
// Drives frame requests and register settings into the descriptor builder,
// with random gaps and back-pressure, and gives the verdict from the monitor.
// ----------------------------------------------------------------------------

module wifi_tx_descriptor_builder_test;
  import wtdb_pkg::*;
  import wtdb_tb_pkg::*;

  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned HoldOffCycles = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] frame_length = '0;
  logic [15:0] frame_ctrl = '0;
  logic        receiver_group = 1'b0;
  logic [11:0] seq_num = '0;
  logic [5:0]  key_slot = '0;
  logic [1:0]  cipher_kind = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [2:0]  word_index;
  logic [31:0] descriptor_word;
  logic [4:0]  queue_id;
  logic [7:0]  endpoint;
  logic        last;

  int unsigned fail_count, frames_done;
  int unsigned frames_sent = 0;
  int unsigned cycle_count = 0;
  frame_t      frame_queue[$];
  logic [7:0]  cur_min_hdr = 8'd24;
  logic [4:0]  cur_max_key = 5'd3;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;
  bit          sink_hold_req = 1'b0;

  always #6 clk = ~clk;

  wifi_tx_descriptor_builder i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .frame_length_i    (frame_length),
    .frame_ctrl_i      (frame_ctrl),
    .receiver_group_i  (receiver_group),
    .seq_num_i         (seq_num),
    .key_slot_i        (key_slot),
    .cipher_kind_i     (cipher_kind),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .word_index_o      (word_index),
    .descriptor_word_o (descriptor_word),
    .queue_id_o        (queue_id),
    .endpoint_o        (endpoint),
    .last_o            (last)
  );

  wtdb_descriptor_monitor u_desc_mon (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .frame_length_i    (frame_length),
    .frame_ctrl_i      (frame_ctrl),
    .receiver_group_i  (receiver_group),
    .seq_num_i         (seq_num),
    .key_slot_i        (key_slot),
    .cipher_kind_i     (cipher_kind),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .status_i          (status),
    .word_index_i      (word_index),
    .descriptor_word_i (descriptor_word),
    .queue_id_i        (queue_id),
    .endpoint_i        (endpoint),
    .last_i            (last),
    .fail_count_o      (fail_count),
    .frames_done_o     (frames_done)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] fctl(input logic [1:0] ftype, input logic [3:0] sub,
                                       input logic [7:0] flags);
    return {flags, sub, ftype, 2'b00};
  endfunction

  function automatic void queue_frame(input logic [15:0] len, input logic [15:0] fc,
                                      input logic grp, input logic [11:0] seq,
                                      input logic [5:0] key, input logic [1:0] cipher);
    frame_t f;
    f.len = len;
    f.fc = fc;
    f.grp = grp;
    f.seq = seq;
    f.key = key;
    f.cipher = cipher;
    frame_queue.push_back(f);
  endfunction

  // most frames pass every check so the descriptor path gets the traffic
  function automatic frame_t random_frame();
    frame_t     f;
    logic [1:0] ftype;
    f.len    = 16'($urandom);
    f.fc     = 16'($urandom);
    f.grp    = 1'($urandom);
    f.seq    = 12'($urandom);
    f.key    = 6'($urandom);
    f.cipher = 2'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      ftype = $urandom_range(0, 1) ? FtypeData : FtypeMgmt;
      f.fc[3:2] = ftype;
      if (ftype == FtypeData) f.fc[7] = 1'b0;
      if ($urandom_range(0, 3) == 0)
        f.len = 16'($urandom_range(cur_min_hdr, 65535));
      else
        f.len = 16'($urandom_range(cur_min_hdr, cur_min_hdr + 64));
      if (ftype == FtypeData && $urandom_range(0, 1)) begin
        f.key = 6'($urandom_range(0, cur_max_key));
        f.cipher = $urandom_range(0, 1) ? CipherCcmp : CipherTkip;
      end else begin
        f.key = KeyNone;
        f.cipher = CipherNone;
      end
    end
    return f;
  endfunction

  function automatic void queue_random_frames(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) frame_queue.push_back(random_frame());
  endfunction

  task automatic send_frame(input frame_t f);
    in_valid       <= 1'b1;
    frame_length   <= f.len;
    frame_ctrl     <= f.fc;
    receiver_group <= f.grp;
    seq_num        <= f.seq;
    key_slot       <= f.key;
    cipher_kind    <= f.cipher;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
  endtask

  // sends everything queued, then waits for the last word of every frame
  task automatic drain_frames();
    frame_t      f;
    int unsigned gap;
    while (frame_queue.size() > 0) begin
      f = frame_queue.pop_front();
      send_frame(f);
      if (frame_queue.size() > 0) begin
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    wait (frames_done >= frames_sent);
  endtask

  // only called with the block idle; upper data bits are junk on purpose
  task automatic load_config(input logic [3:0] cnt, input logic [7:0] hi,
                             input logic [7:0] nrm, input logic [7:0] lo,
                             input logic [7:0] min_hdr, input logic [4:0] max_key);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EP_COUNT;
    cfg_data  <= {4'($urandom), cnt};
    @(posedge clk);
    cfg_index <= REG_EP_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_EP_NORMAL;
    cfg_data  <= nrm;
    @(posedge clk);
    cfg_index <= REG_EP_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_MIN_HDR;
    cfg_data  <= min_hdr;
    @(posedge clk);
    cfg_index <= REG_MAX_KEY;
    cfg_data  <= {3'($urandom), max_key};
    @(posedge clk);
    cfg_index <= RegSpareLo;
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    cfg_index <= RegSpareHi;
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_min_hdr = min_hdr;
    cur_max_key = max_key;
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall = HoldOffCycles;
      end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
        stall = pick_gap() + 1;
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[wifi_tx_descriptor_builder] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: min length 24, key slots 0..3, one endpoint
    queue_frame(16'd24, fctl(FtypeMgmt, 4'h0, 8'h00), 1'b0, 12'h000, KeyNone, CipherNone);
    queue_frame(16'd23, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h001, KeyNone, CipherNone);
    // short length wins over a bad key slot
    queue_frame(16'd0, fctl(FtypeData, 4'h0, 8'h00), 1'b1, 12'h002, 6'h3e, CipherTkip);
    queue_frame(16'hffff, fctl(FtypeData, 4'h7, 8'hff), 1'b0, 12'hfff, KeyNone, CipherNone);
    queue_frame(16'd100, fctl(FtypeData, 4'h0, 8'h00), 1'b1, 12'h5a5, KeyNone, CipherNone);
    queue_frame(16'd100, fctl(FtypeData, 4'h0, 8'h00), 1'b1, 12'ha5a, 6'd3, CipherCcmp);
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h123, 6'd0, CipherTkip);
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b1, 12'h124, 6'd1, CipherTkip);
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h125, 6'd2, CipherCcmp);
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h126, 6'd4, CipherCcmp);
    // slots -2, -32 and 31
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h127, 6'h3e, CipherCcmp);
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h128, 6'h20, CipherTkip);
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h129, 6'd31, CipherTkip);
    // cipher without key, key without cipher
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h12a, KeyNone, CipherTkip);
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h12b, 6'd1, CipherNone);
    // control, extension and QoS data are not handled
    queue_frame(16'd64, fctl(FtypeCtrl, 4'h0, 8'h00), 1'b0, 12'h12c, KeyNone, CipherNone);
    queue_frame(16'd64, fctl(FtypeExt, 4'h0, 8'h00), 1'b0, 12'h12d, KeyNone, CipherNone);
    queue_frame(16'd64, fctl(FtypeData, 4'h8, 8'h00), 1'b0, 12'h12e, KeyNone, CipherNone);
    // encrypted management, unknown cipher, type check before cipher check
    queue_frame(16'd64, fctl(FtypeMgmt, 4'h0, 8'h00), 1'b0, 12'h12f, 6'd1, CipherCcmp);
    queue_frame(16'd64, fctl(FtypeData, 4'h0, 8'h00), 1'b0, 12'h130, 6'd2, CipherOther);
    queue_frame(16'd64, fctl(FtypeCtrl, 4'h0, 8'h00), 1'b0, 12'h131, 6'd1, CipherOther);
    queue_frame(16'd200, fctl(FtypeMgmt, 4'hf, 8'hff) | 16'h3, 1'b1, 12'hfff, KeyNone,
                CipherNone);
    queue_frame(16'd24, fctl(FtypeData, 4'h7, 8'h00), 1'b1, 12'h800, KeyNone, CipherNone);
    drain_frames();

    // no endpoints, every length and slots -1..31 allowed
    load_config(4'd0, 8'hff, 8'h00, 8'h00, 8'd0, 5'd31);
    queue_random_frames(50);
    drain_frames();

    // two endpoints, longest header minimum, only slot 0; no idling here
    src_calm = 1'b1;
    sink_calm = 1'b1;
    load_config(4'd2, 8'h00, 8'hff, 8'h55, 8'd255, 5'd0);
    queue_random_frames(50);
    drain_frames();
    src_calm = 1'b0;
    sink_calm = 1'b0;

    // three endpoints; result side held off while a burst backs up the input
    load_config(4'd3, 8'ha5, 8'h5a, 8'hff, 8'd24, 5'd3);
    sink_hold_req = 1'b1;
    src_calm = 1'b1;
    queue_random_frames(24);
    drain_frames();
    src_calm = 1'b0;
    queue_random_frames(40);
    drain_frames();

    load_config(4'd15, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom_range(0, 64)), 5'($urandom));
    queue_random_frames(50);
    drain_frames();

    load_config(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 5'($urandom));
    queue_random_frames(50);
    drain_frames();

    // catch any stray word after the last frame
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("[wifi_tx_descriptor_builder] OK");
    else
      $display("[wifi_tx_descriptor_builder] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wtdb_pkg.sv
rtl/wtdb_build.sv
rtl/wtdb_serial.sv
rtl/wifi_tx_descriptor_builder.sv
tb/wtdb_tb_pkg.sv
tb/wtdb_descriptor_monitor.sv
tb/wifi_tx_descriptor_builder_test.sv
